// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: hw/rtl/b32e_pkg.sv
// Types, codes, generator constants and alphabet of the bech32 encoder.
package b32e_pkg;

  localparam int PREFIX_MAX_DEF = 63;
  localparam int CHK_W          = 30;
  localparam int SYM_W          = 5;
  localparam int CHAR_W         = 8;

  localparam logic [CHK_W-1:0] CHK_INIT = CHK_W'(1);

  localparam logic [CHK_W-1:0] GEN_POLY [SYM_W] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [CHAR_W-1:0] SEP_CHAR = 8'h31;
  localparam logic [CHAR_W-1:0] UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z  = 8'h5a;

  typedef logic [1:0] req_t;
  localparam req_t REQ_PREFIX = 2'd0;
  localparam req_t REQ_DATA   = 2'd1;
  localparam req_t REQ_FINISH = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_LONG = 2'd1;
  localparam status_t STAT_LATE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_SEP,
    ST_RD,
    ST_RPL,
    ST_BODY,
    ST_SYM,
    ST_PAD,
    ST_ZERO,
    ST_CHK
  } state_t;

  function automatic logic [CHAR_W-1:0] b32_char(input logic [SYM_W-1:0] sym);
    return ALPHABET[{~sym, 3'b000} +: CHAR_W];
  endfunction

endpackage

// File: hw/rtl/bech32_string_encoder.sv
// Bech32 string encoder: prefix echo, 8-to-5 regrouping and checksum sequencer.
//
// Input channel (in_valid/in_ready): one request per item. in_req_type selects
// a prefix character, a data byte or finish; in_value carries the character or
// byte. Output channel (out_valid/out_ready): one ASCII character per item, with
// out_last on the final checksum character and out_status holding the sticky
// error code of the current string.
// The block takes one request at a time; in_ready is high only when it is idle.
// A prefix character is echoed from one state. A data byte passes a dispatch
// state and then emits one or two symbols. The first data byte or finish of a
// string first emits the separator and then reads each stored prefix character
// back from the prefix RAM, one entry at a time, to fold its low part.
// Finish emits a padding symbol when bits are left over, runs six zero steps and
// emits six checksum characters. All checksum folding goes through one shared
// step unit, one symbol per cycle while the output register is not stalled.
// Results wait in a single output register; while the receiver stalls, the
// sequencer holds in a state that emits, so no new request is taken while it waits there.
// Reset returns the checksum to one and clears the prefix count, leftover bits,
// data flag and status; the output register comes up empty.
`include "assert_macros.svh"

module bech32_string_encoder import b32e_pkg::*; #(
  parameter int PREFIX_MAX = PREFIX_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CHAR_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last,
  output logic [1:0]        out_status
);

  localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
  localparam int CW = $clog2(PREFIX_MAX + 1);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [CHAR_W-1:0] val_r, val_nxt;
  logic [CHK_W-1:0]  chk_r, chk_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [3:0]        left_bits_r, left_bits_nxt;
  logic [2:0]        left_cnt_r, left_cnt_nxt;
  logic              started_r, started_nxt;
  status_t           status_r, status_nxt;
  logic [AW-1:0]     rep_idx_r, rep_idx_nxt;
  logic [2:0]        step_cnt_r, step_cnt_nxt;
  logic [11:0]       acc_r, acc_nxt;
  logic [3:0]        bits_r, bits_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              out_free;
  logic              in_fire;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              step_en;
  logic [SYM_W-1:0]  step_sym;
  logic [CHK_W-1:0]  step_out;
  logic              ram_we;
  logic              ram_re;
  logic [SYM_W-1:0]  ram_rdata;
  logic [CHAR_W-1:0] fold_char;
  logic [11:0]       acc_shift;
  logic [SYM_W-1:0]  sym_cur;
  logic [SYM_W-1:0]  pad_sym;
  logic              rep_done;
  logic              prefix_ok;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  assign fold_char = ((val_r >= UPPER_A) && (val_r <= UPPER_Z)) ? (val_r | 8'h20) : val_r;
  assign acc_shift = acc_r >> (bits_r - 4'd5);
  assign sym_cur   = acc_shift[SYM_W-1:0];
  assign pad_sym   = SYM_W'({1'b0, left_bits_r} << (3'd5 - left_cnt_r));
  assign rep_done  = (({1'b0, CW'(rep_idx_r)} + (CW+1)'(1)) == {1'b0, cnt_r});
  assign prefix_ok = !started_r && (cnt_r < CW'(PREFIX_MAX));

  b32e_polymod u_polymod (
    .chk_i (chk_r),
    .sym_i (step_sym),
    .chk_o (step_out)
  );

  b32e_ram #(
    .WIDTH (SYM_W),
    .DEPTH (PREFIX_MAX)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (fold_char[SYM_W-1:0]),
    .re    (ram_re),
    .raddr (rep_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type) inside
            REQ_PREFIX: begin
              if (prefix_ok) begin
                state_nxt = ST_PREFIX;
              end
            end
            REQ_DATA, REQ_FINISH: begin
              state_nxt = started_r ? ST_BODY : ST_SEP;
            end
            default: ;
          endcase
        end
      end
      ST_PREFIX: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEP: begin
        if (out_free) begin
          state_nxt = (cnt_r != '0) ? ST_RD : ST_BODY;
        end
      end
      ST_RD:   state_nxt = ST_RPL;
      ST_RPL:  state_nxt = rep_done ? ST_BODY : ST_RD;
      ST_BODY: state_nxt = (req_r == REQ_DATA) ? ST_SYM : ST_PAD;
      ST_SYM: begin
        if (bits_r < 4'd5) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if ((left_cnt_r == 3'd0) || out_free) begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (step_cnt_r == 3'd5) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (out_free && (step_cnt_r == 3'd5)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_char = SEP_CHAR;
    emit_last = 1'b0;
    step_en   = 1'b0;
    step_sym  = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_r)
      ST_PREFIX: begin
        emit      = out_free;
        emit_char = fold_char;
        step_en   = out_free;
        step_sym  = {2'b00, fold_char[7:5]};
        ram_we    = out_free;
      end
      ST_SEP: begin
        emit    = out_free;
        step_en = out_free;
      end
      ST_RD: ram_re = 1'b1;
      ST_RPL: begin
        step_en  = 1'b1;
        step_sym = ram_rdata;
      end
      ST_SYM: begin
        if (bits_r >= 4'd5) begin
          emit      = out_free;
          emit_char = b32_char(sym_cur);
          step_en   = out_free;
          step_sym  = sym_cur;
        end
      end
      ST_PAD: begin
        if (left_cnt_r != 3'd0) begin
          emit      = out_free;
          emit_char = b32_char(pad_sym);
          step_en   = out_free;
          step_sym  = pad_sym;
        end
      end
      ST_ZERO: step_en = 1'b1;
      ST_CHK: begin
        emit      = out_free;
        emit_char = b32_char(chk_r[CHK_W-1 -: SYM_W]);
        emit_last = (step_cnt_r == 3'd5);
      end
      default: ;
    endcase
  end

  always_comb begin
    req_nxt        = req_r;
    val_nxt        = val_r;
    chk_nxt        = step_en ? step_out : chk_r;
    cnt_nxt        = cnt_r;
    left_bits_nxt  = left_bits_r;
    left_cnt_nxt   = left_cnt_r;
    started_nxt    = started_r;
    status_nxt     = status_r;
    rep_idx_nxt    = rep_idx_r;
    step_cnt_nxt   = step_cnt_r;
    acc_nxt        = acc_r;
    bits_nxt       = bits_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt = in_req_type;
          val_nxt = in_value;
          if ((in_req_type == REQ_PREFIX) && (status_r == STAT_OK)) begin
            if (started_r) begin
              status_nxt = STAT_LATE;
            end else if (!prefix_ok) begin
              status_nxt = STAT_LONG;
            end
          end
        end
      end
      ST_PREFIX: begin
        if (emit) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_SEP: rep_idx_nxt = '0;
      ST_RPL: rep_idx_nxt = rep_idx_r + AW'(1);
      ST_BODY: begin
        started_nxt  = 1'b1;
        acc_nxt      = {left_bits_r, val_r};
        bits_nxt     = {1'b0, left_cnt_r} + 4'd8;
        step_cnt_nxt = '0;
      end
      ST_SYM: begin
        if (bits_r >= 4'd5) begin
          if (emit) begin
            bits_nxt = bits_r - 4'd5;
          end
        end else begin
          left_cnt_nxt  = bits_r[2:0];
          left_bits_nxt = acc_r[3:0] & ~(4'hf << bits_r[2:0]);
        end
      end
      ST_ZERO: begin
        step_cnt_nxt = step_cnt_r + 3'd1;
        if (step_cnt_r == 3'd5) begin
          chk_nxt      = step_out ^ CHK_INIT;
          step_cnt_nxt = '0;
        end
      end
      ST_CHK: begin
        if (emit) begin
          chk_nxt      = {chk_r[CHK_W-SYM_W-1:0], {SYM_W{1'b0}}};
          step_cnt_nxt = step_cnt_r + 3'd1;
          if (emit_last) begin
            chk_nxt       = CHK_INIT;
            cnt_nxt       = '0;
            left_bits_nxt = '0;
            left_cnt_nxt  = '0;
            started_nxt   = 1'b0;
            status_nxt    = STAT_OK;
          end
        end
      end
      default: ;
    endcase

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = emit_char;
      out_last_nxt   = emit_last;
      out_status_nxt = status_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_r       <= CHK_INIT;
      cnt_r       <= '0;
      left_bits_r <= '0;
      left_cnt_r  <= '0;
      started_r   <= 1'b0;
      status_r    <= STAT_OK;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      cnt_r       <= cnt_nxt;
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
      started_r   <= started_nxt;
      status_r    <= status_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    rep_idx_r    <= rep_idx_nxt;
    acc_r        <= acc_nxt;
    bits_r       <= bits_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CW'(PREFIX_MAX), "prefix count past limit")
  `ASSERT_NEVER(a_left_bound, clk, rst_n, left_cnt_r > 3'd4, "leftover count above four")
  `ASSERT_NEVER(a_store_after_data, clk, rst_n, ram_we && started_r, "prefix stored after data")
  `ASSERT_HOLDS(a_clear_after_last, clk, rst_n, (emit && emit_last) |=> ((chk_r == CHK_INIT) && (cnt_r == '0) && !started_r && (status_r == STAT_OK)), "string state not cleared after last character")

endmodule

// File: hw/rtl/b32e_ram.sv
// Generic single-port-write RAM with registered read.
module b32e_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/b32e_polymod.sv
// One bech32 checksum step: shift in a 5-bit symbol and fold in the generator.
module b32e_polymod import b32e_pkg::*; (
  input  logic [CHK_W-1:0] chk_i,
  input  logic [SYM_W-1:0] sym_i,
  output logic [CHK_W-1:0] chk_o
);

  always_comb begin
    chk_o = {chk_i[CHK_W-SYM_W-1:0], sym_i};
    for (int j = 0; j < SYM_W; j++) begin
      if (chk_i[CHK_W-SYM_W+j]) begin
        chk_o = chk_o ^ GEN_POLY[j];
      end
    end
  end

endmodule

// File: test/bech32_string_encoder_tb.sv
// Self-checking testbench for the bech32 string encoder with its own checksum predictor.
`timescale 1ns / 1ps

module bech32_string_encoder_tb import b32e_pkg::*; ();

  localparam int HRP_MAX = PREFIX_MAX_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam req_t REQ_RESERVED = 2'd3;

  typedef struct {
    req_t kind;
    logic [7:0] val;
  } enc_req_t;

  typedef struct {
    logic [7:0] ch;
    logic last;
    status_t status;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_PREFIX;
  logic [7:0] in_value = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_char;
  logic out_last;
  logic [1:0] out_status;

  bech32_string_encoder i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_last(out_last),
    .out_status(out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  string b32_set = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  logic [29:0] chk_acc = CHK_INIT;
  logic [4:0] hrp_low [HRP_MAX];
  int hrp_len = 0;
  logic [3:0] carry_bits = '0;
  int carry_cnt = 0;
  bit in_body = 1'b0;
  status_t str_status = STAT_OK;

  enc_req_t pending_reqs[$];
  enc_char_t exp_chars[$];

  int errors = 0;
  int queued_items = 0;
  int reqs_accepted = 0;
  int chars_checked = 0;
  int strings_closed = 0;
  int cycle_cnt = 0;

  function automatic logic [29:0] chk_fold(input logic [29:0] c, input logic [4:0] sym);
    logic [29:0] r;
    r = {c[24:0], sym};
    for (int j = 0; j < 5; j++) begin
      if (c[25+j]) r ^= GEN_POLY[j];
    end
    return r;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch = ch;
    e.last = last;
    e.status = str_status;
    exp_chars.push_back(e);
  endtask

  task automatic emit_sym(input logic [4:0] sym);
    push_char(b32_set[sym], 1'b0);
    chk_acc = chk_fold(chk_acc, sym);
  endtask

  task automatic open_body();
    if (!in_body) begin
      push_char(SEP_CHAR, 1'b0);
      chk_acc = chk_fold(chk_acc, 5'd0);
      for (int i = 0; i < hrp_len; i++) chk_acc = chk_fold(chk_acc, hrp_low[i]);
      in_body = 1'b1;
    end
  endtask

  task automatic predict_request(input req_t kind, input logic [7:0] val);
    logic [7:0] c;
    logic [11:0] acc;
    int bits;
    logic [29:0] fin;
    case (kind)
      REQ_PREFIX: begin
        if (in_body) begin
          if (str_status == STAT_OK) str_status = STAT_LATE;
        end else if (hrp_len >= HRP_MAX) begin
          if (str_status == STAT_OK) str_status = STAT_LONG;
        end else begin
          c = val;
          if (c >= UPPER_A && c <= UPPER_Z) c = c + 8'd32;
          push_char(c, 1'b0);
          chk_acc = chk_fold(chk_acc, {2'b00, c[7:5]});
          hrp_low[hrp_len] = c[4:0];
          hrp_len++;
        end
      end
      REQ_DATA: begin
        open_body();
        acc = {carry_bits, val};
        bits = carry_cnt + 8;
        while (bits >= 5) begin
          bits -= 5;
          emit_sym(5'((acc >> bits) & 12'd31));
        end
        carry_cnt = bits;
        carry_bits = 4'(acc & ((12'd1 << bits) - 12'd1));
      end
      REQ_FINISH: begin
        open_body();
        if (carry_cnt > 0) emit_sym(5'((carry_bits << (5 - carry_cnt)) & 5'd31));
        for (int i = 0; i < 6; i++) chk_acc = chk_fold(chk_acc, 5'd0);
        fin = chk_acc ^ 30'd1;
        for (int i = 0; i < 6; i++) push_char(b32_set[(fin >> (5 * (5 - i))) & 31], i == 5);
        chk_acc = CHK_INIT;
        hrp_len = 0;
        carry_bits = '0;
        carry_cnt = 0;
        in_body = 1'b0;
        str_status = STAT_OK;
        strings_closed++;
      end
      default: ;
    endcase
  endtask

  task automatic add_req(input req_t kind, input logic [7:0] val);
    enc_req_t r;
    r.kind = kind;
    r.val = val;
    pending_reqs.push_back(r);
    if (kind != REQ_RESERVED) queued_items++;
  endtask

  function automatic logic [7:0] pick_hrp_char();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 8'($urandom_range(97, 122));
    if (sel < 7) return 8'($urandom_range(48, 57));
    if (sel < 9) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_string(input int n_hrp, input int n_data, input bit noisy);
    for (int i = 0; i < n_hrp; i++) add_req(REQ_PREFIX, pick_hrp_char());
    for (int i = 0; i < n_data; i++) begin
      add_req(REQ_DATA, 8'($urandom_range(0, 255)));
      if (noisy && $urandom_range(0, 3) == 0) add_req(REQ_PREFIX, pick_hrp_char());
      if (noisy && $urandom_range(0, 5) == 0) begin
        add_req(REQ_RESERVED, 8'($urandom_range(0, 255)));
      end
    end
    if (!noisy || $urandom_range(0, 2) != 0) add_req(REQ_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  enc_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_req_type, in_value);
        reqs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_req.kind;
          in_value <= next_req.val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ?
                         $urandom_range(20, 60) : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: segments of full rate, random stalls and a rotating pattern, plus one long hold
  int seg_left = 0;
  int seg_mode = 0;
  logic [7:0] stall_pat = 8'b1101_0110;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int rx_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_seen++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!hold_done && rx_seen >= 60) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(8, 64);
        end else begin
          seg_left--;
        end
        case (seg_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            stall_pat = {stall_pat[6:0], stall_pat[7]};
            out_ready <= stall_pat[0];
          end
        endcase
      end
    end
  end

  enc_char_t exp_c;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b status %0d",
                 $time, out_char, out_last, out_status);
        errors++;
      end else begin
        exp_c = exp_chars.pop_front();
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, exp_c.ch, out_char);
          errors++;
        end
        if (out_last !== exp_c.last) begin
          $display("%0t: out_last mismatch: expected %b, actual %b", $time, exp_c.last, out_last);
          errors++;
        end
        if (out_status !== exp_c.status) begin
          $display("%0t: out_status mismatch: expected %0d, actual %0d",
                   $time, exp_c.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests pending and %0d characters expected",
               $time, pending_reqs.size(), exp_chars.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // directed: case folding, prefix extremes, data extremes, finish
    add_req(REQ_PREFIX, 8'h41);
    add_req(REQ_PREFIX, 8'h5a);
    add_req(REQ_PREFIX, 8'h61);
    add_req(REQ_PREFIX, 8'h7a);
    add_req(REQ_PREFIX, 8'h40);
    add_req(REQ_PREFIX, 8'h5b);
    add_req(REQ_PREFIX, 8'h00);
    add_req(REQ_PREFIX, 8'hff);
    add_req(REQ_DATA, 8'h00);
    add_req(REQ_RESERVED, 8'hff);
    add_req(REQ_DATA, 8'hff);
    add_req(REQ_DATA, 8'ha5);
    add_req(REQ_FINISH, 8'h00);
    // empty string, then prefix with no data
    add_req(REQ_FINISH, 8'hff);
    add_req(REQ_PREFIX, 8'h42);
    add_req(REQ_PREFIX, 8'h63);
    add_req(REQ_FINISH, 8'h5a);
    // late prefix
    add_req(REQ_PREFIX, 8'h78);
    add_req(REQ_DATA, 8'h5a);
    add_req(REQ_PREFIX, 8'h71);
    add_req(REQ_DATA, 8'h3c);
    add_req(REQ_FINISH, 8'h00);

    queue_string($urandom_range(1, 6), $urandom_range(0, 5), 1'b0);
    // over-long prefix, then a late one in the same string
    for (int i = 0; i < HRP_MAX + 2; i++) add_req(REQ_PREFIX, pick_hrp_char());
    add_req(REQ_DATA, 8'($urandom_range(0, 255)));
    add_req(REQ_PREFIX, pick_hrp_char());
    add_req(REQ_FINISH, 8'h00);
    while (queued_items < 220) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_string($urandom_range(0, 4), $urandom_range(0, 6), 1'b1);
      end else begin
        queue_string($urandom_range(0, 8), $urandom_range(0, 10), 1'b0);
      end
    end
    add_req(REQ_FINISH, 8'h00);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || exp_chars.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (exp_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, exp_chars.size());
      errors++;
    end
    $display("Run covered %0d requests over %0d strings and checked %0d characters,",
             reqs_accepted, strings_closed, chars_checked);
    $display("including an over-long prefix, late prefixes and a %0d-cycle receiver hold.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
